// ===== rtl/abrs_pkg.sv =====
package abrs_pkg;

   // Geometry of the bin store.
   localparam int BINS            = 360;
   localparam int BIN_W           = $clog2(BINS);
   localparam int HALF_WINDOW     = 5;
   localparam int WINDOW          = 2 * HALF_WINDOW;
   localparam int WIN_CNT_W       = $clog2(WINDOW + 1);
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int ANGLE_HALF      = (1 << ANGLE_FRAC_BITS) >> 1;

   // Field widths.
   localparam int ANGLE_W   = 15;
   localparam int RANGE_W   = 16;
   localparam int BEARING_W = 9;
   localparam int STAMP_W   = 32;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int ENTRY_W   = RANGE_W + STAMP_W;

   // Register reset values.
   localparam logic [CSR_W-1:0] MIN_RANGE_RST = 16'd100;
   localparam logic [CSR_W-1:0] MAX_RANGE_RST = 16'd3000;
   localparam logic [CSR_W-1:0] MAX_AGE_RST   = 16'd500;
   localparam logic [CSR_W-1:0] MARGIN_RST    = 16'd50;

   // Command codes.
   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RANGE = 2'd0,
      CSR_MAX_RANGE = 2'd1,
      CSR_MAX_AGE   = 2'd2,
      CSR_MARGIN    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Configuration as seen by the engine.
   typedef struct packed {
      logic [CSR_W-1:0] min_range;
      logic [CSR_W-1:0] max_range;
      logic [CSR_W-1:0] max_age;
      logic [CSR_W-1:0] agreement_margin;
   } cfg_type;

   // Request beat handed to the engine.
   typedef struct packed {
      logic                 valid;
      logic                 command;
      logic [ANGLE_W-1:0]   sample_angle;
      logic [RANGE_W-1:0]   sample_range;
      logic [BEARING_W-1:0] query_bearing;
      logic [STAMP_W-1:0]   now_ms;
   } req_type;

   // Finished query result offered to the output register.
   typedef struct packed {
      logic               valid;
      logic [RANGE_W-1:0] range_out;
      logic               found;
   } result_type;

endpackage

// ===== rtl/angle_binned_range_store.sv =====
// A store beat is written to the bin memory as it is accepted. A query beat reads the ten
// window bins through the single read port of the bin memory, evaluates each bin as it comes
// back, and then hands its result to the output register once that is free. Only one beat is
// in work at a time; a finished result waits in the output register while the next beat is
// accepted. Reset is synchronous; afterwards the bin memory is cleared in a pass over all
// bins, during which no request beat is accepted. Registers return to their reset values at once.
module angle_binned_range_store (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [abrs_pkg::ANGLE_W-1:0]       req_sample_angle,
   input  logic [abrs_pkg::RANGE_W-1:0]       req_sample_range,
   input  logic [abrs_pkg::BEARING_W-1:0]     req_query_bearing,
   input  logic [abrs_pkg::STAMP_W-1:0]       req_now_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [abrs_pkg::RANGE_W-1:0]       rsp_range_out,
   output logic                               rsp_found,
   input  logic                               csr_we,
   input  logic [abrs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [abrs_pkg::CSR_W-1:0]         csr_wdata
);
   import abrs_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RANGE_W-1:0] rsp_range_ff, rsp_range_in;
   logic               rsp_found_ff, rsp_found_in;
   req_type            req;
   result_type         result;
   logic               slot_free;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_RANGE: cfg_in.min_range        = csr_wdata;
            CSR_MAX_RANGE: cfg_in.max_range        = csr_wdata;
            CSR_MAX_AGE:   cfg_in.max_age          = csr_wdata;
            CSR_MARGIN:    cfg_in.agreement_margin = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_range        <= MIN_RANGE_RST;
         cfg_ff.max_range        <= MAX_RANGE_RST;
         cfg_ff.max_age          <= MAX_AGE_RST;
         cfg_ff.agreement_margin <= MARGIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.valid         = req_valid;
   assign req.command       = req_command;
   assign req.sample_angle  = req_sample_angle;
   assign req.sample_range  = req_sample_range;
   assign req.query_bearing = req_query_bearing;
   assign req.now_ms        = req_now_ms;

   abrs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req),
      .req_stall (req_stall),
      .slot_free (slot_free),
      .result    (result)
   );

   // Output register: takes a result when empty or when its beat leaves this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_range_in = rsp_range_ff;
      rsp_found_in = rsp_found_ff;
      if (result.valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_range_in = result.range_out;
         rsp_found_in = result.found;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_range_ff <= rsp_range_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_out = rsp_range_ff;
   assign rsp_found     = rsp_found_ff;

endmodule

// ===== rtl/abrs_bin_ram.sv =====
module abrs_bin_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 360,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/abrs_engine.sv =====
module abrs_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  abrs_pkg::cfg_type    cfg,
   input  abrs_pkg::req_type    req,
   output logic                 req_stall,
   input  logic                 slot_free,
   output abrs_pkg::result_type result
);
   import abrs_pkg::*;

   state_type             state_ff, state_in;
   logic [BIN_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [BIN_W-1:0]      idx_ff, idx_in;
   logic [WIN_CNT_W-1:0]  issue_cnt_ff, issue_cnt_in;
   logic [WIN_CNT_W-1:0]  proc_cnt_ff, proc_cnt_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [STAMP_W-1:0]    now_ff, now_in;
   logic [RANGE_W-1:0]    prev_ff, prev_in;
   logic                  have_prev_ff, have_prev_in;
   logic                  hit_ff, hit_in;
   logic [RANGE_W-1:0]    result_ff, result_in;

   logic                  wr_en;
   logic [BIN_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic                  rd_en;
   logic [ENTRY_W-1:0]    rd_data;

   logic [ANGLE_W:0]      angle_round;
   logic [ANGLE_W:0]      angle_bin_wide;
   logic [BIN_W-1:0]      store_bin;
   logic                  range_ok;
   logic [BEARING_W:0]    bearing_wide;
   logic [BIN_W-1:0]      centre;
   logic [BIN_W-1:0]      window_start;
   logic [RANGE_W-1:0]    bin_range;
   logic [STAMP_W-1:0]    bin_stamp;
   logic [STAMP_W-1:0]    bin_age;
   logic                  bin_counts;
   logic [RANGE_W-1:0]    range_diff;
   logic                  agrees;

   abrs_bin_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (BINS),
      .ADDR_W (BIN_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Round the sample angle to the nearest bin; anything past the last bin goes to bin 0.
   assign angle_round    = {1'b0, req.sample_angle} + (ANGLE_W + 1)'(ANGLE_HALF);
   assign angle_bin_wide = angle_round >> ANGLE_FRAC_BITS;
   assign store_bin      = (angle_bin_wide >= (ANGLE_W + 1)'(BINS)) ? '0
                                                                   : angle_bin_wide[BIN_W-1:0];
   assign range_ok       = (req.sample_range > cfg.min_range) &&
                           (req.sample_range < cfg.max_range);

   // Centre of the query window, taken modulo the bin count, then the first bin of the window.
   assign bearing_wide = {1'b0, req.query_bearing};
   assign centre       = (bearing_wide >= (BEARING_W + 1)'(BINS))
                         ? BIN_W'(bearing_wide - (BEARING_W + 1)'(BINS))
                         : BIN_W'(bearing_wide);
   assign window_start = (centre < BIN_W'(HALF_WINDOW))
                         ? BIN_W'(centre + BIN_W'(BINS - HALF_WINDOW))
                         : BIN_W'(centre - BIN_W'(HALF_WINDOW));

   // Evaluate the bin that came back from the memory this cycle.
   assign bin_range  = rd_data[ENTRY_W-1:STAMP_W];
   assign bin_stamp  = rd_data[STAMP_W-1:0];
   assign bin_age    = now_ff - bin_stamp;
   assign bin_counts = (bin_range != '0) && (bin_age < {{(STAMP_W-CSR_W){1'b0}}, cfg.max_age});
   assign range_diff = (bin_range > prev_ff) ? (bin_range - prev_ff) : (prev_ff - bin_range);
   assign agrees     = range_diff < cfg.agreement_margin;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         issue_cnt_ff <= '0;
         proc_cnt_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         have_prev_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_cnt_ff <= issue_cnt_in;
         proc_cnt_ff  <= proc_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         have_prev_ff <= have_prev_in;
         hit_ff       <= hit_in;
      end
   end

   // Payload registers of the scan.
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      now_ff    <= now_in;
      prev_ff   <= prev_in;
      result_ff <= result_in;
   end

   // Sequencer: clearing pass, store writes, the window scan and the result hand-off.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      idx_in       = idx_ff;
      issue_cnt_in = issue_cnt_ff;
      proc_cnt_in  = proc_cnt_ff;
      rd_pend_in   = 1'b0;
      now_in       = now_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      hit_in       = hit_ff;
      result_in    = result_ff;
      req_stall    = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = store_bin;
      wr_data      = '0;
      rd_en        = 1'b0;
      result.valid     = 1'b0;
      result.range_out = result_ff;
      result.found     = hit_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            if (clr_addr_ff == BIN_W'(BINS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            req_stall = 1'b0;
            if (req.valid) begin
               if (req.command == CMD_STORE) begin
                  wr_en   = 1'b1;
                  wr_addr = store_bin;
                  wr_data = range_ok ? {req.sample_range, req.now_ms} : '0;
               end else begin
                  idx_in       = window_start;
                  issue_cnt_in = '0;
                  proc_cnt_in  = '0;
                  now_in       = req.now_ms;
                  have_prev_in = 1'b0;
                  hit_in       = 1'b0;
                  result_in    = '0;
                  state_in     = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // Issue one read a cycle until the whole window has been asked for.
            if (issue_cnt_ff != WIN_CNT_W'(WINDOW)) begin
               rd_en        = 1'b1;
               rd_pend_in   = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               idx_in       = (idx_ff == BIN_W'(BINS - 1)) ? '0 : BIN_W'(idx_ff + 1'b1);
            end
            // Consume the bin read in the previous cycle; the first agreement wins.
            if (rd_pend_ff) begin
               proc_cnt_in = proc_cnt_ff + 1'b1;
               if (bin_counts && !hit_ff) begin
                  if (have_prev_ff && agrees) begin
                     hit_in    = 1'b1;
                     result_in = bin_range;
                  end
                  prev_in      = bin_range;
                  have_prev_in = 1'b1;
               end
               if (proc_cnt_ff == WIN_CNT_W'(WINDOW - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            result.valid = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/sv/tb_angle_binned_range_store.sv =====
import abrs_pkg::*;

// One answer to a query beat, as the block should return it.
typedef struct {
   logic [RANGE_W-1:0] range_mm;
   logic               found;
} query_answer_type;

// Scoreboard: keeps its own copy of the bin store and the registers, works out the
// answer to every accepted query and checks the result beats against them in order.
class range_store_scoreboard;
   bit [RANGE_W-1:0] bin_range [BINS];
   bit [STAMP_W-1:0] bin_stamp [BINS];
   bit [CSR_W-1:0]   min_range        = MIN_RANGE_RST;
   bit [CSR_W-1:0]   max_range        = MAX_RANGE_RST;
   bit [CSR_W-1:0]   max_age          = MAX_AGE_RST;
   bit [CSR_W-1:0]   agreement_margin = MARGIN_RST;
   query_answer_type awaited_answers [$];
   int               errors;
   int               stores_seen;
   int               queries_seen;
   int               agreed_seen;

   function void note_config(csr_index_type index, logic [CSR_W-1:0] value);
      case (index)
         CSR_MIN_RANGE: min_range = value;
         CSR_MAX_RANGE: max_range = value;
         CSR_MAX_AGE:   max_age = value;
         CSR_MARGIN:    agreement_margin = value;
         default: ;
      endcase
   endfunction

   // Scan the window around the centre bin, keep the fresh non-empty bins and return
   // the first one that agrees with the kept bin before it.
   function query_answer_type window_answer(logic [BEARING_W-1:0] bearing,
                                            logic [STAMP_W-1:0] now_ms);
      query_answer_type answer;
      bit [RANGE_W-1:0] kept [$];
      bit [STAMP_W-1:0] age;
      int               centre;
      int               idx;
      int               k;
      int               diff;
      answer.range_mm = '0;
      answer.found    = 1'b0;
      centre = int'(bearing) % BINS;
      for (k = -HALF_WINDOW; k < HALF_WINDOW; k++) begin
         idx = (centre + BINS + k) % BINS;
         age = now_ms - bin_stamp[idx];
         if (bin_range[idx] != '0 && age < {16'd0, max_age}) begin
            kept.push_back(bin_range[idx]);
         end
      end
      for (k = 1; k < kept.size(); k++) begin
         diff = int'(kept[k]) - int'(kept[k-1]);
         if (diff < 0) begin
            diff = -diff;
         end
         if (diff < int'(agreement_margin)) begin
            answer.range_mm = kept[k];
            answer.found    = 1'b1;
            break;
         end
      end
      return answer;
   endfunction

   // An accepted request beat: a store updates the bins, a query queues its answer.
   function void note_request(logic cmd, logic [ANGLE_W-1:0] angle,
                              logic [RANGE_W-1:0] range_mm, logic [BEARING_W-1:0] bearing,
                              logic [STAMP_W-1:0] now_ms);
      int unsigned slot;
      if (cmd == CMD_STORE) begin
         stores_seen++;
         // Round to the nearest degree; anything at or past the last half degree is bin 0.
         slot = (int'(angle) + ANGLE_HALF) >> ANGLE_FRAC_BITS;
         if (slot >= BINS) begin
            slot = 0;
         end
         if (range_mm > min_range && range_mm < max_range) begin
            bin_range[slot] = range_mm;
            bin_stamp[slot] = now_ms;
         end else begin
            bin_range[slot] = '0;
            bin_stamp[slot] = '0;
         end
      end else begin
         queries_seen++;
         awaited_answers.push_back(window_answer(bearing, now_ms));
      end
   endfunction

   task report_mismatch(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task check_response(logic [RANGE_W-1:0] range_mm, logic found);
      query_answer_type want;
      if (awaited_answers.size() == 0) begin
         report_mismatch($sformatf("result beat range_out=%0d found=%0b with no query open",
                                   range_mm, found));
         return;
      end
      want = awaited_answers.pop_front();
      if (want.found) begin
         agreed_seen++;
      end
      if (range_mm !== want.range_mm) begin
         report_mismatch($sformatf("range_out %0d, expected %0d", range_mm, want.range_mm));
      end
      if (found !== want.found) begin
         report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
      end
   endtask

   function int pending();
      return awaited_answers.size();
   endfunction
endclass

module tb_angle_binned_range_store;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 200;
   localparam int IDLE_PCT      = 31;
   localparam int ANGLE_SPAN    = BINS << ANGLE_FRAC_BITS;
   localparam int DEG_UNITS     = 1 << ANGLE_FRAC_BITS;

   logic                   clock;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic                   req_command       = CMD_STORE;
   logic [ANGLE_W-1:0]     req_sample_angle  = '0;
   logic [RANGE_W-1:0]     req_sample_range  = '0;
   logic [BEARING_W-1:0]   req_query_bearing = '0;
   logic [STAMP_W-1:0]     req_now_ms        = '0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic [RANGE_W-1:0]     rsp_range_out;
   logic                   rsp_found;
   logic                   csr_we            = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index         = CSR_MIN_RANGE;
   logic [CSR_W-1:0]       csr_wdata         = '0;

   range_store_scoreboard  sb;
   int                     cycle_count       = 0;
   int                     hold_asks         = 0;
   int                     hold_served       = 0;
   int                     hold_left         = 0;
   bit                     tx_idle_on        = 1'b1;
   bit                     rx_idle_on        = 1'b1;
   logic [STAMP_W-1:0]     clock_ms;
   int                     focus_bin;
   int                     focus_permille;

   angle_binned_range_store u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_sample_angle  (req_sample_angle),
      .req_sample_range  (req_sample_range),
      .req_query_bearing (req_query_bearing),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_range_out     (rsp_range_out),
      .rsp_found         (rsp_found),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Watch both channels and hand every accepted beat to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_command, req_sample_angle, req_sample_range,
                            req_query_bearing, req_now_ms);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_range_out, rsp_found);
         end
      end
   end

   // Result side: random stalls, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_served != hold_asks) begin
         hold_served <= hold_asks;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rx_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Offer one request beat, after an optional random gap, and wait until it is taken.
   task automatic send_item(input logic cmd, input logic [ANGLE_W-1:0] angle,
                            input logic [RANGE_W-1:0] range_mm,
                            input logic [BEARING_W-1:0] bearing,
                            input logic [STAMP_W-1:0] now_ms);
      while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_sample_angle  <= angle;
      req_sample_range  <= range_mm;
      req_query_bearing <= bearing;
      req_now_ms        <= now_ms;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending until every queued answer has come back, then let stores finish.
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.note_config(index, value);
   endtask

   task automatic apply_settings(input logic [CSR_W-1:0] min_r, input logic [CSR_W-1:0] max_r,
                                 input logic [CSR_W-1:0] age, input logic [CSR_W-1:0] margin);
      wait_for_answers();
      write_csr(CSR_MIN_RANGE, min_r);
      write_csr(CSR_MAX_RANGE, max_r);
      write_csr(CSR_MAX_AGE, age);
      write_csr(CSR_MARGIN, margin);
      csr_we <= 1'b0;
   endtask

   // A distance that the current limits accept, near the level of the current burst.
   function automatic logic [RANGE_W-1:0] near_dist();
      int lo;
      int hi;
      int d;
      lo = int'(sb.min_range) + 1;
      hi = int'(sb.max_range) - 1;
      if (lo > hi) begin
         return RANGE_W'($urandom);
      end
      d = lo + (hi - lo) / 1000 * focus_permille + int'($urandom_range(0, 60)) - 30;
      if (d < lo) begin
         d = lo;
      end
      if (d > hi) begin
         d = hi;
      end
      return RANGE_W'(d);
   endfunction

   // Bursts of stores and queries around one bearing with a running clock, mixed with
   // random noise beats.
   task automatic run_random_phase(input int count, input bit with_hold);
      int n;
      int roll;
      int angle;
      int bearing;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            focus_bin      = $urandom_range(0, BINS - 1);
            focus_permille = $urandom_range(0, 1000);
         end
         if (with_hold && n == count / 3) begin
            hold_asks <= hold_asks + 1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            send_item(1'($urandom_range(0, 1)), ANGLE_W'($urandom_range(0, 32767)),
                      RANGE_W'($urandom), BEARING_W'($urandom_range(0, 511)), $urandom);
         end else if (roll < 70) begin
            // Mostly small time steps, now and then a jump that ages the bins out.
            if ($urandom_range(0, 19) == 0) begin
               clock_ms += $urandom_range(0, 1000);
            end else begin
               clock_ms += $urandom_range(0, 15);
            end
            angle = focus_bin * DEG_UNITS + int'($urandom_range(0, 10 * DEG_UNITS))
                    - 5 * DEG_UNITS;
            if (angle < 0) begin
               angle += ANGLE_SPAN;
            end
            if (angle >= ANGLE_SPAN) begin
               angle -= ANGLE_SPAN;
            end
            send_item(CMD_STORE, ANGLE_W'(angle), near_dist(), '0, clock_ms);
         end else begin
            bearing = (focus_bin + BINS + int'($urandom_range(0, 6)) - 3) % BINS;
            send_item(CMD_QUERY, '0, '0, BEARING_W'(bearing), clock_ms);
         end
      end
   endtask

   initial begin
      sb       = new();
      clock_ms = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset settings. Neighbours across bin 0 and bin 359,
      // age counted across the wrap of the millisecond clock.
      send_item(CMD_STORE, 15'd0,     16'd101,   '0, 32'hFFFF_FFF0);
      // An exact half degree rounds up into bin 1.
      send_item(CMD_STORE, 15'd32,    16'd150,   '0, 32'hFFFF_FFF8);
      send_item(CMD_STORE, 15'd23007, 16'd120,   '0, 32'hFFFF_FFFF);
      send_item(CMD_QUERY, '0, '0, 9'd0,   32'h0000_0010);
      send_item(CMD_QUERY, '0, '0, 9'd359, 32'h0000_0010);
      // Bins 0 and 1 differ by one less than the margin.
      send_item(CMD_QUERY, '0, '0, 9'd5,   32'h0000_0010);
      // Half a degree short of a full turn, and angles past the range, land in bin 0;
      // distances at the limits, zero and full scale are rejected and clear the bin.
      send_item(CMD_STORE, 15'd23008, 16'd130,   '0, 32'd20);
      send_item(CMD_STORE, 15'd32767, 16'd3000,  '0, 32'd21);
      send_item(CMD_STORE, 15'd23039, 16'd100,   '0, 32'd22);
      send_item(CMD_STORE, 15'd31,    16'd0,     '0, 32'd23);
      send_item(CMD_STORE, 15'd256,   16'd65535, '0, 32'd24);
      send_item(CMD_QUERY, '0, '0, 9'd0,   32'd30);
      // Ranges that never agree, and an empty window.
      send_item(CMD_STORE, 15'd12672, 16'd500,   '0, 32'd31);
      send_item(CMD_STORE, 15'd12736, 16'd700,   '0, 32'd32);
      send_item(CMD_STORE, 15'd12800, 16'd900,   '0, 32'd33);
      send_item(CMD_QUERY, '0, '0, 9'd200, 32'd40);
      send_item(CMD_QUERY, '0, '0, 9'd100, 32'd40);
      // Bearings past 359 wrap round.
      send_item(CMD_QUERY, '0, '0, 9'd511, 32'd41);
      send_item(CMD_QUERY, '0, '0, 9'd360, 32'd42);
      send_item(CMD_QUERY, '0, '0, 9'd365, 32'd43);
      // Everything far too old.
      send_item(CMD_QUERY, '0, '0, 9'd0,   32'h8000_0000);

      // Random traffic, with one long hold-off on the result side.
      run_random_phase(150, 1'b1);
      // Widest limits: every kept pair agrees.
      apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_phase(110, 1'b0);
      // Narrowest limits: nothing is stored and no bin counts.
      apply_settings(16'hFFFF, 16'd0, 16'd0, 16'd0);
      run_random_phase(60, 1'b0);
      // Random limits, with neither side idling.
      apply_settings(CSR_W'($urandom_range(0, 400)), CSR_W'($urandom_range(1500, 6000)),
                     CSR_W'($urandom_range(30, 1500)), CSR_W'($urandom_range(1, 120)));
      tx_idle_on = 1'b0;
      rx_idle_on <= 1'b0;
      run_random_phase(130, 1'b0);
      // Back to the reset values.
      apply_settings(MIN_RANGE_RST, MAX_RANGE_RST, MAX_AGE_RST, MARGIN_RST);
      tx_idle_on = 1'b1;
      rx_idle_on <= 1'b1;
      run_random_phase(80, 1'b0);

      wait_for_answers();
      $display("Covered %0d store beats and %0d query beats, %0d of them with agreeing bins,",
               sb.stores_seen, sb.queries_seen, sb.agreed_seen);
      $display("over five register settings, with random stalls and one long output hold-off.");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/abrs_pkg.sv
rtl/abrs_bin_ram.sv
rtl/abrs_engine.sv
rtl/angle_binned_range_store.sv
tb/sv/tb_angle_binned_range_store.sv
